/* src/mfl_pkg.sv */
package mfl_pkg;

  localparam int unsigned FixedIds      = 12;
  localparam int unsigned IdsPerSection = 25;
  localparam int unsigned NumWidths     = 25;
  localparam int unsigned GroupSize     = 5;
  localparam int unsigned NumGroups     = NumWidths / GroupSize;
  localparam int unsigned BaseShift     = 50;
  // q = (x * RecipK) >> RecipShift equals x / 25 for all x < 8192
  localparam int unsigned RecipShift    = 23;
  localparam logic [18:0] RecipK        = 19'd335545;

  typedef struct packed {
    logic [12:0] field_id;
    logic [31:0] header_word;
    logic [63:0] section_word;
    logic        has_limit;
    logic [14:0] limit_words;
  } in_t;

  typedef struct packed {
    logic        present;
    logic [14:0] field_offset;
    logic [1:0]  field_width;
    logic [8:0]  section_index;
  } out_t;

  typedef struct packed {
    logic        ok;
    logic [49:0] widths;
    logic [4:0]  idx;
    logic [13:0] base;
    logic [8:0]  body;
    logic        has_limit;
    logic [14:0] limit;
    logic [8:0]  sidx;
  } dec_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  width;
    logic [14:0] offset;
    logic        has_limit;
    logic [14:0] limit;
    logic [8:0]  sidx;
  } sum_t;

endpackage

/* src/message_field_locator_core.sv */
// Field locator for serialized messages.
// Input channel: drive in_item (field id, header word, section word, limit)
// and pulse start; a transaction is taken at each clock edge where start is
// high and busy is low. busy stays low: a new transaction may enter on
// every cycle.
// Result channel: out_valid is high for exactly one cycle with out_item
// (present, field_offset, field_width, section_index). The receiver cannot
// stall; results must be taken when shown.
// Pipeline: four stages plus the output register. Throughput: one
// transaction per cycle through the five-stage pipeline (reciprocal
// multiply, section select, masked width sums, offset add, limit check).
// Caller supplies the section word at index (field_id-12)/25; the index is
// echoed in section_index.
// Reset (rst_n low, synchronous) drops all in-flight transactions; no
// result strobes until new transactions are accepted.
module message_field_locator_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  mfl_pkg::in_t  in_item,
  output logic          out_valid,
  output mfl_pkg::out_t out_item
);

  logic          accept;
  logic          dec_valid;
  mfl_pkg::dec_t dec;
  logic          sum_valid;
  mfl_pkg::sum_t sum;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  mfl_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_item   (in_item),
    .dec_valid (dec_valid),
    .dec       (dec)
  );

  mfl_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (dec_valid),
    .dec       (dec),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

  // stage 5: width and end-limit check
  logic          out_valid_r;
  mfl_pkg::out_t out_r;
  mfl_pkg::out_t out_nxt;
  logic [15:0]   field_end;
  logic          fits;
  logic          ok;

  always_comb begin
    field_end = {1'b0, sum.offset} + {14'b0, sum.width};
    fits      = !sum.has_limit || (field_end <= {1'b0, sum.limit});
    ok        = sum.ok && (sum.width != 2'd0) && fits;
    out_nxt.present       = ok;
    out_nxt.field_offset  = ok ? sum.offset : 15'd0;
    out_nxt.field_width   = ok ? sum.width : 2'd0;
    out_nxt.section_index = sum.sidx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sum_valid;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

/* src/mfl_decode.sv */
module mfl_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  mfl_pkg::in_t  in_item,
  output logic          dec_valid,
  output mfl_pkg::dec_t dec
);

  // stage 1: section index by reciprocal multiply
  logic          v1_r;
  mfl_pkg::in_t  item1_r;
  logic          fixed1_r;
  logic [12:0]   x1_r;
  logic [8:0]    q1_r;

  logic          fixed1_nxt;
  logic [12:0]   x1_nxt;
  logic [31:0]   prod;

  always_comb begin
    fixed1_nxt = (in_item.field_id < 13'(mfl_pkg::FixedIds));
    x1_nxt     = fixed1_nxt ? 13'd0 : (in_item.field_id - 13'(mfl_pkg::FixedIds));
    prod       = 32'(x1_nxt) * 32'(mfl_pkg::RecipK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    item1_r  <= in_item;
    fixed1_r <= fixed1_nxt;
    x1_r     <= x1_nxt;
    q1_r     <= prod[mfl_pkg::RecipShift +: 9];
  end

  // stage 2: position in section, width word select, range checks
  logic          v2_r;
  mfl_pkg::dec_t dec_r;
  mfl_pkg::dec_t dec_nxt;
  logic [13:0]   q25;
  logic [13:0]   pos_full;
  logic [7:0]    sections;

  always_comb begin
    q25      = {1'b0, q1_r, 4'b0} + {2'b0, q1_r, 3'b0} + {5'b0, q1_r};
    pos_full = {1'b0, x1_r} - q25;
    sections = item1_r.header_word[7:0];

    dec_nxt.body      = {sections, 1'b1};
    dec_nxt.has_limit = item1_r.has_limit;
    dec_nxt.limit     = item1_r.limit_words;
    dec_nxt.sidx      = q1_r;
    dec_nxt.ok        = !(item1_r.has_limit && ({6'b0, dec_nxt.body} >= item1_r.limit_words))
                        && (fixed1_r || (q1_r < {1'b0, sections}));
    if (fixed1_r) begin
      dec_nxt.widths = {26'b0, item1_r.header_word[31:8]};
      dec_nxt.idx    = {1'b0, item1_r.field_id[3:0]};
      dec_nxt.base   = 14'd0;
    end else begin
      dec_nxt.widths = item1_r.section_word[49:0];
      dec_nxt.idx    = pos_full[4:0];
      dec_nxt.base   = item1_r.section_word[mfl_pkg::BaseShift +: 14];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    dec_r <= dec_nxt;
  end

  assign dec_valid = v2_r;
  assign dec       = dec_r;

endmodule

/* src/mfl_sum.sv */
module mfl_sum (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          dec_valid,
  input  mfl_pkg::dec_t dec,
  output logic          sum_valid,
  output mfl_pkg::sum_t sum
);

  // stage 3: masked group sums and width select
  logic                                v3_r;
  logic [mfl_pkg::NumGroups-1:0][3:0]  grp_r;
  logic [mfl_pkg::NumGroups-1:0][3:0]  grp_nxt;
  logic [1:0]                          width3_r;
  logic [1:0]                          width3_nxt;
  mfl_pkg::dec_t                       dec3_r;

  always_comb begin
    width3_nxt = 2'd0;
    for (int i = 0; i < mfl_pkg::NumWidths; i++) begin
      if (dec.idx == 5'(i)) width3_nxt = dec.widths[2*i +: 2];
    end
    for (int g = 0; g < mfl_pkg::NumGroups; g++) begin
      grp_nxt[g] = 4'd0;
      for (int j = 0; j < mfl_pkg::GroupSize; j++) begin
        if (5'(g * mfl_pkg::GroupSize + j) < dec.idx) begin
          grp_nxt[g] = grp_nxt[g]
                     + {2'b0, dec.widths[2*(g*mfl_pkg::GroupSize + j) +: 2]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= dec_valid;
    end
    grp_r    <= grp_nxt;
    width3_r <= width3_nxt;
    dec3_r   <= dec;
  end

  // stage 4: offset = body + base + group sums
  logic          v4_r;
  mfl_pkg::sum_t sum_r;
  mfl_pkg::sum_t sum_nxt;
  logic [6:0]    gsum;

  always_comb begin
    gsum = 7'd0;
    for (int g = 0; g < mfl_pkg::NumGroups; g++) begin
      gsum = gsum + {3'b0, grp_r[g]};
    end
    sum_nxt.ok        = dec3_r.ok;
    sum_nxt.width     = width3_r;
    sum_nxt.offset    = {6'b0, dec3_r.body} + {1'b0, dec3_r.base} + {8'b0, gsum};
    sum_nxt.has_limit = dec3_r.has_limit;
    sum_nxt.limit     = dec3_r.limit;
    sum_nxt.sidx      = dec3_r.sidx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    sum_r <= sum_nxt;
  end

  assign sum_valid = v4_r;
  assign sum       = sum_r;

endmodule

/* src/mfl_checker.sv */
module mfl_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input mfl_pkg::in_t  in_item,
  input logic          out_valid,
  input mfl_pkg::out_t out_item
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("result missing 5 cycles after transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 5))
    else $error("result without matching transaction");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.present) |->
      (out_item.field_offset == 15'd0 && out_item.field_width == 2'd0))
    else $error("absent field with nonzero offset or width");

  a_present_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.present) |->
      (out_item.field_width != 2'd0 && out_item.field_offset != 15'd0))
    else $error("present field with zero width or offset");

  a_fixed_sidx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_item.field_id, 5) < 13'd12)) |->
      (out_item.section_index == 9'd0))
    else $error("nonzero section index for header field");

endmodule

bind message_field_locator_core mfl_checker u_mfl_checker (.*);
